// ===== hw/rtl/i2cms_pkg.sv =====
// Shared types and constants for the I2C master bit sequencer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package i2cms_pkg;

   typedef logic [2:0] opcode_type;

   // Command codes; idle is encoded as OP_TICK in the active command register
   localparam opcode_type OP_TICK      = 3'd0;
   localparam opcode_type OP_START     = 3'd1;
   localparam opcode_type OP_STOP      = 3'd2;
   localparam opcode_type OP_WRITE     = 3'd3;
   localparam opcode_type OP_READ      = 3'd4;
   localparam opcode_type OP_SEND_ACK  = 3'd5;
   localparam opcode_type OP_RECV_ACK  = 3'd6;
   localparam opcode_type OP_NONE      = 3'd7;

   localparam int unsigned TICKS_W = 16;
   localparam int unsigned PHASE_W = 5;
   localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd5;

   typedef struct packed {
      opcode_type opcode;
      logic [7:0] data_byte;
      logic       ack_value;
      logic       sda_sample;
   } req_item_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_input_mode;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       ack_received;
      logic       rejected;
   } rsp_item_type;

   // Number of line phases in each command
   function automatic logic [PHASE_W-1:0] phase_total(input opcode_type cmd);
      logic [PHASE_W-1:0] n;
      begin
         unique case (cmd)
            OP_START:    n = 5'd3;
            OP_STOP:     n = 5'd3;
            OP_WRITE:    n = 5'd24;
            OP_READ:     n = 5'd16;
            OP_SEND_ACK: n = 5'd5;
            OP_RECV_ACK: n = 5'd3;
            default:     n = 5'd0;
         endcase
         return n;
      end
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/i2c_master_bit_sequencer.sv =====
// I2C master bit sequencer: top level joining input register, step logic
// and result register. Depends on i2cms_pkg, i2cms_in_stage, i2cms_core, i2cms_out_stage.
//
// Use: a timebase sends tick items (opcode zero) on req_ together with the
// sampled SDA pin; commands (start, stop, write, read, send ack, receive ack)
// are sent on the same channel between ticks. Every request transfer yields
// exactly one result transfer on rsp_ with the SCL level, SDA drive and
// direction, busy, done, the last received byte and acknowledge, and a
// rejected flag for a command that arrived while busy.
// csr_ writes the phase length in ticks; it is always ready and should be
// written only while the sequencer is idle.
// Path: a request item is held in the input register, passes the state update
// and its result is held in the result register, which drives rsp_valid.
// Throughput: one item per cycle unless stalled, set by the single state update step.
// When the receiver stalls, the result register holds its item and the input
// register takes one more request before req_ready drops.
// Reset: both lines released high, SDA in output mode, idle, phase length 5.
`default_nettype none

module i2c_master_bit_sequencer
   import i2cms_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire req_item_type       req_payload,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rsp_item_type            rsp_payload,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [TICKS_W-1:0] csr_data
);

   logic         item_valid;
   req_item_type item;
   logic         drain;
   logic         step;
   rsp_item_type result;

   // Process the held item when the result register has room
   assign step      = item_valid && drain;
   assign csr_ready = 1'b1;

   i2cms_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .drain       (drain),
      .item_valid  (item_valid),
      .item        (item)
   );

   i2cms_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item      (item),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .result    (result)
   );

   i2cms_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .load        (step),
      .result      (result),
      .drain       (drain),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/i2cms_in_stage.sv =====
// Input register of the I2C master bit sequencer: holds one accepted transfer.
// Depends on i2cms_pkg for the request item type.
`default_nettype none

module i2cms_in_stage
   import i2cms_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_item_type req_payload,
   input  wire logic         drain,
   output logic              item_valid,
   output req_item_type      item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;

   // Take a new transfer whenever the held one leaves this cycle or none is held
   always_comb begin
      req_ready = !valid_ff || drain;
      valid_in  = valid_ff;
      item_in   = item_ff;
      if (req_ready) begin
         valid_in = req_valid;
         item_in  = req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/i2cms_core.sv =====
// Line sequencing state and step logic; one item per cycle on step.
// Depends on i2cms_pkg for opcodes, item types and the phase count table.
`default_nettype none

module i2cms_core
   import i2cms_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire req_item_type       item,
   input  wire logic               csr_write,
   input  wire logic [TICKS_W-1:0] csr_data,
   output rsp_item_type            result
);

   opcode_type         cmd_ff, cmd_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [TICKS_W-1:0] tick_ff, tick_in;
   logic [TICKS_W-1:0] ticks_ff, ticks_in;
   logic [1:0]         bit_phase_ff, bit_phase_in;
   logic [7:0]         shift_ff, shift_in;
   logic [7:0]         rx_ff, rx_in;
   logic               scl_ff, scl_in;
   logic               sda_ff, sda_in;
   logic               dir_ff, dir_in;
   logic               ack_ff, ack_in;

   logic               done;
   logic               rej;
   logic               enter_en;
   opcode_type         enter_cmd;
   logic [TICKS_W-1:0] limit;
   logic [TICKS_W-1:0] tick_inc;

   // Phase length, a zero setting counts as one tick
   assign limit    = (ticks_ff == '0) ? {{(TICKS_W-1){1'b0}}, 1'b1} : ticks_ff;
   assign tick_inc = tick_ff + {{(TICKS_W-1){1'b0}}, 1'b1};

   // Advance the sequence by one item
   always_comb begin
      cmd_in       = cmd_ff;
      phase_in     = phase_ff;
      tick_in      = tick_ff;
      bit_phase_in = bit_phase_ff;
      shift_in     = shift_ff;
      rx_in        = rx_ff;
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      dir_in       = dir_ff;
      ack_in       = ack_ff;
      ticks_in     = csr_write ? csr_data : ticks_ff;
      done         = 1'b0;
      rej          = 1'b0;
      enter_en     = 1'b0;
      enter_cmd    = cmd_ff;

      if (step) begin
         priority if (item.opcode == OP_TICK) begin
            if (cmd_ff != OP_TICK) begin
               tick_in = tick_inc;
               if (tick_inc >= limit) begin
                  tick_in = '0;
                  // Sample SDA at the end of a high clock phase
                  if (cmd_ff == OP_READ && phase_ff[0]) begin
                     shift_in = {shift_ff[6:0], item.sda_sample};
                  end else if (cmd_ff == OP_RECV_ACK && phase_ff == 5'd1) begin
                     ack_in = !item.sda_sample;
                  end
                  phase_in     = phase_ff + 5'd1;
                  bit_phase_in = (bit_phase_ff == 2'd2) ? 2'd0 : bit_phase_ff + 2'd1;
                  if (phase_in >= phase_total(cmd_ff)) begin
                     if (cmd_ff == OP_READ) begin
                        rx_in = shift_in;
                     end
                     cmd_in   = OP_TICK;
                     phase_in = '0;
                     done     = 1'b1;
                  end else begin
                     enter_en = 1'b1;
                  end
               end
            end
         end else if (item.opcode != OP_NONE) begin
            if (cmd_ff != OP_TICK) begin
               rej = 1'b1;
            end else begin
               cmd_in       = item.opcode;
               phase_in     = '0;
               tick_in      = '0;
               bit_phase_in = 2'd0;
               if (item.opcode == OP_WRITE) begin
                  shift_in = item.data_byte;
               end else if (item.opcode == OP_READ) begin
                  shift_in = '0;
               end else if (item.opcode == OP_SEND_ACK) begin
                  shift_in = {7'd0, !item.ack_value};
               end
               enter_cmd = item.opcode;
               enter_en  = 1'b1;
            end
         end else begin
            // Drop the unused opcode without touching any state
         end
      end

      // Apply the line levels of the phase just entered
      if (enter_en) begin
         unique case (enter_cmd)
            OP_START: begin
               if (phase_in == 5'd0) begin
                  dir_in = 1'b0;
                  sda_in = 1'b1;
                  scl_in = 1'b1;
               end else if (phase_in == 5'd1) begin
                  sda_in = 1'b0;
               end else begin
                  scl_in = 1'b0;
               end
            end
            OP_STOP: begin
               if (phase_in == 5'd0) begin
                  dir_in = 1'b0;
                  scl_in = 1'b0;
                  sda_in = 1'b0;
               end else if (phase_in == 5'd1) begin
                  scl_in = 1'b1;
               end else begin
                  sda_in = 1'b1;
               end
            end
            OP_WRITE: begin
               if (phase_in == 5'd0) begin
                  dir_in = 1'b0;
               end
               if (bit_phase_in == 2'd0) begin
                  scl_in = 1'b0;
               end else if (bit_phase_in == 2'd1) begin
                  sda_in   = shift_in[7];
                  shift_in = {shift_in[6:0], 1'b0};
               end else begin
                  scl_in = 1'b1;
               end
            end
            OP_READ: begin
               if (phase_in == 5'd0) begin
                  dir_in = 1'b1;
               end
               scl_in = phase_in[0];
            end
            OP_SEND_ACK: begin
               if (phase_in == 5'd0) begin
                  dir_in = 1'b0;
                  scl_in = 1'b0;
               end else if (phase_in == 5'd1) begin
                  sda_in = shift_in[0];
               end else if (phase_in == 5'd2) begin
                  scl_in = 1'b1;
               end else if (phase_in == 5'd3) begin
                  scl_in = 1'b0;
               end else begin
                  sda_in = 1'b1;
               end
            end
            OP_RECV_ACK: begin
               if (phase_in == 5'd0) begin
                  dir_in = 1'b1;
                  scl_in = 1'b0;
               end else if (phase_in == 5'd1) begin
                  scl_in = 1'b1;
               end else begin
                  scl_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Result of this item, from the updated state
   always_comb begin
      result.scl_level      = scl_in;
      result.sda_level      = sda_in;
      result.sda_input_mode = dir_in;
      result.busy_res       = (cmd_in != OP_TICK);
      result.done_res       = done;
      result.read_data      = rx_in;
      result.ack_received   = ack_in;
      result.rejected       = rej;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff       <= OP_TICK;
         phase_ff     <= '0;
         tick_ff      <= '0;
         ticks_ff     <= TICKS_RESET;
         bit_phase_ff <= 2'd0;
         shift_ff     <= '0;
         rx_ff        <= '0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         dir_ff       <= 1'b0;
         ack_ff       <= 1'b0;
      end else begin
         cmd_ff       <= cmd_in;
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         ticks_ff     <= ticks_in;
         bit_phase_ff <= bit_phase_in;
         shift_ff     <= shift_in;
         rx_ff        <= rx_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         dir_ff       <= dir_in;
         ack_ff       <= ack_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/i2cms_out_stage.sv =====
// Result register of the I2C master bit sequencer: holds one result transfer.
// Depends on i2cms_pkg for the result item type.
`default_nettype none

module i2cms_out_stage
   import i2cms_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         load,
   input  wire rsp_item_type result,
   output logic              drain,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_item_type      rsp_payload
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff, item_in;

   // Room for a new result when empty or the held one is taken this cycle
   always_comb begin
      drain    = !valid_ff || rsp_ready;
      valid_in = valid_ff && !rsp_ready;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = item_ff;

endmodule

`default_nettype wire
